[rtl/srsr_pkg.sv]
// ----------------------------------------------------------------------------
// srsr_pkg
// Shared types and constants for the serial speech ROM reader.
// ----------------------------------------------------------------------------
package srsr_pkg;

  localparam int ROM_BYTES   = 32768;
  localparam int ROM_AW      = $clog2(ROM_BYTES);
  localparam int ADDR_W      = 18;
  localparam int LIM_W       = ADDR_W + 1;
  localparam int IDX_W       = 15;
  localparam int IDX_EXT_W   = ROM_AW + IDX_W;
  localparam int LEN_W       = 16;
  localparam int SHIFT_W     = 5;
  localparam int BITS_LEFT_W = 4;

  localparam logic [LEN_W-1:0]       ROM_LENGTH_RESET = LEN_W'(32768);
  localparam logic [SHIFT_W-1:0]     SHIFT_SAT        = SHIFT_W'(20);
  localparam logic [BITS_LEFT_W-1:0] BYTE_BITS        = BITS_LEFT_W'(8);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_NIBBLE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_BRANCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH2,
    S_DONE
  } state_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic accept;     // item taken; first store access issued
    logic rd_second;  // first byte present, second byte read issued
    logic commit;     // update state and load the result register
  } ctl_t;

endpackage

[rtl/srsr_ram.sv]
// ----------------------------------------------------------------------------
// srsr_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module srsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/srsr_ctrl.sv]
// ----------------------------------------------------------------------------
// srsr_ctrl
// Sequencer for the speech ROM reader: handshakes and datapath strobes.
// ----------------------------------------------------------------------------
module srsr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output srsr_pkg::ctl_t   ctl
);
  import srsr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;
  cmd_t   in_cmd;

  assign in_cmd   = cmd_t'(cmd);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (in_cmd == CMD_READ || in_cmd == CMD_BRANCH) begin
            state_next = S_FETCH2;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FETCH2: begin
        ctl.rd_second = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        // The result register must be empty or draining before it is reloaded.
        if (out_free) begin
          ctl.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/srsr_dp.sv]
// ----------------------------------------------------------------------------
// srsr_dp
// Datapath: byte store, address and bit counters, result register.
// ----------------------------------------------------------------------------
module srsr_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  srsr_pkg::ctl_t                     ctl,
  input  logic                               cfg_wr_en,
  input  logic [srsr_pkg::LEN_W-1:0]         cfg_wr_data,
  input  logic [1:0]                         cmd,
  input  logic [srsr_pkg::IDX_W-1:0]         rom_index,
  input  logic [7:0]                         rom_byte,
  input  logic [3:0]                         nibble,
  input  logic [3:0]                         bit_count,
  output logic [7:0]                         bits_out,
  output logic [srsr_pkg::ADDR_W-1:0]        address_now
);
  import srsr_pkg::*;

  // Architectural state
  logic [ADDR_W-1:0]      rom_address;
  logic [SHIFT_W-1:0]     nibble_shift;
  logic [BITS_LEFT_W-1:0] bits_left;
  logic [LEN_W-1:0]       rom_length;

  // Item latched at accept
  cmd_t                   cur_cmd;
  logic [3:0]             cur_nibble;
  logic [3:0]             cur_count;
  logic [7:0]             byte0;

  // Store port
  logic                   ram_en;
  logic                   ram_we;
  logic [ROM_AW-1:0]      ram_addr;
  logic [7:0]             ram_rdata;
  logic [IDX_EXT_W-1:0]   idx_ext;
  logic                   idx_ok;

  // Next values
  logic [ADDR_W-1:0]      rom_address_next;
  logic [SHIFT_W-1:0]     nibble_shift_next;
  logic [BITS_LEFT_W-1:0] bits_left_next;
  logic [7:0]             bits_next;

  // Working signals
  logic [LIM_W-1:0]       lim;
  logic [ADDR_W-1:0]      addr_p1;
  logic [LIM_W-1:0]       addr_p1_wide;
  logic                   in_range;
  logic                   next_ok;
  logic                   word_ok;
  logic [3:0]             cnt_clip;
  logic [3:0]             cnt;
  logic [7:0]             mask;
  logic [BITS_LEFT_W-1:0] bl_dec;
  logic [4:0]             bl_sum;
  logic [15:0]            word;
  logic [15:0]            word_sh;
  logic [21:0]            nib_tmp;
  logic [13:0]            branch_low;

  srsr_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (rom_byte),
    .rdata (ram_rdata)
  );

  assign idx_ext = IDX_EXT_W'(rom_index);
  assign idx_ok  = LIM_W'(rom_index) < LIM_W'(ROM_BYTES);

  assign lim          = (LIM_W'(rom_length) > LIM_W'(ROM_BYTES)) ? LIM_W'(ROM_BYTES)
                                                                   : LIM_W'(rom_length);
  assign addr_p1      = rom_address + ADDR_W'(1);
  assign addr_p1_wide = LIM_W'(rom_address) + LIM_W'(1);
  assign in_range     = LIM_W'(rom_address) < lim;
  assign next_ok      = LIM_W'(addr_p1) < lim;
  assign word_ok      = addr_p1_wide < lim;

  // Store access: a write or the first byte read at accept, the second read after.
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = rom_address[ROM_AW-1:0];
    if (ctl.accept) begin
      if (cmd_t'(cmd) == CMD_WRITE) begin
        ram_en   = idx_ok;
        ram_we   = 1'b1;
        ram_addr = idx_ext[ROM_AW-1:0];
      end else begin
        ram_en = 1'b1;
      end
    end else if (ctl.rd_second) begin
      ram_en   = 1'b1;
      ram_addr = addr_p1[ROM_AW-1:0];
    end
  end

  always_comb begin
    cnt_clip = (cur_count > 4'd8) ? 4'd8 : cur_count;
    // The first read after an address load delivers one bit fewer.
    cnt      = (nibble_shift != '0 && cnt_clip != 4'd0) ? cnt_clip - 4'd1 : cnt_clip;
    mask     = 8'hFF >> (4'd8 - cnt);
    bl_dec   = bits_left - cnt;
    bl_sum   = 5'(bits_left) + 5'd8 - 5'(cnt);
    word     = {byte0, next_ok ? ram_rdata : 8'h00};
    word_sh  = word >> bl_sum[3:0];
    nib_tmp  = ((22'(rom_address) & ~(22'hF << nibble_shift))
               | (22'(cur_nibble) << nibble_shift));
    if (word_ok) begin
      branch_low = {byte0[5:0], ram_rdata};
    end else if (in_range) begin
      branch_low = {byte0[5:0], 8'h00};
    end else begin
      branch_low = '0;
    end

    rom_address_next  = rom_address;
    nibble_shift_next = nibble_shift;
    bits_left_next    = bits_left;
    bits_next         = 8'h00;
    unique case (cur_cmd)
      CMD_WRITE: begin
      end
      CMD_NIBBLE: begin
        if (nibble_shift < SHIFT_SAT) begin
          rom_address_next  = nib_tmp[ADDR_W-1:0];
          nibble_shift_next = nibble_shift + SHIFT_W'(4);
        end
        bits_left_next = BYTE_BITS;
      end
      CMD_READ: begin
        nibble_shift_next = '0;
        if (in_range) begin
          if (cnt < bits_left) begin
            bits_left_next = bl_dec;
            bits_next      = (byte0 >> bl_dec) & mask;
          end else begin
            rom_address_next = addr_p1;
            bits_left_next   = bl_sum[3:0];
            bits_next        = word_sh[7:0] & mask;
          end
        end
      end
      CMD_BRANCH: begin
        rom_address_next = {rom_address[ADDR_W-1:14], branch_low};
        bits_left_next   = BYTE_BITS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_address  <= '0;
      nibble_shift <= '0;
      bits_left    <= '0;
      rom_length   <= ROM_LENGTH_RESET;
    end else begin
      if (cfg_wr_en) begin
        rom_length <= cfg_wr_data;
      end
      if (ctl.commit) begin
        rom_address  <= rom_address_next;
        nibble_shift <= nibble_shift_next;
        bits_left    <= bits_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cur_cmd    <= cmd_t'(cmd);
      cur_nibble <= nibble;
      cur_count  <= bit_count;
    end
    if (ctl.rd_second) begin
      byte0 <= ram_rdata;
    end
    if (ctl.commit) begin
      bits_out    <= bits_next;
      address_now <= rom_address_next;
    end
  end

endmodule

[rtl/speech_rom_serial_reader_core.sv]
// ----------------------------------------------------------------------------
// speech_rom_serial_reader_core
// Serial speech ROM reader: byte store, nibble address load, bit reads, branches.
// ----------------------------------------------------------------------------
// Each word on the input channel carries one command and yields one result
// word. A store write or an address nibble goes from acceptance to the done
// state, which loads the result register once it is free; the input is free
// again after that load. A bit read or a read-and-branch passes through the
// second-fetch state first: the two bytes it may need come in turn through
// the single port of the byte store, whose read data is registered.
// One command is in flight at a time, but a finished result waits in its own
// register, so the next command is taken while the result is still stalled.
// The ROM length register may be written only while no command is in flight.
module speech_rom_serial_reader_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [srsr_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [srsr_pkg::IDX_W-1:0]  rom_index,
  input  logic [7:0]                  rom_byte,
  input  logic [3:0]                  nibble,
  input  logic [3:0]                  bit_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  bits_out,
  output logic [srsr_pkg::ADDR_W-1:0] address_now
);
  import srsr_pkg::*;

  ctl_t ctl;

  srsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  srsr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .rom_index   (rom_index),
    .rom_byte    (rom_byte),
    .nibble      (nibble),
    .bit_count   (bit_count),
    .bits_out    (bits_out),
    .address_now (address_now)
  );

endmodule

[tb/tb_speech_rom_serial_reader_core.sv]
// ----------------------------------------------------------------------------
// tb_speech_rom_serial_reader_core
// Self-checking testbench for the serial speech ROM reader core.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the byte store, the address, the
// nibble shift and the bit counter, and predicts one result word for every
// command word the core accepts. A short directed opening hits the field
// extremes and the corner cases. It is followed by phases of random address
// loads, bit reads and branches under several ROM lengths and idle patterns.
// Every read or branch is preceded by writes to any store byte it could
// fetch, so no read or branch fetches a never-written entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_speech_rom_serial_reader_core;
  import srsr_pkg::*;

  localparam int unsigned ADDR_MASK    = 32'h3FFFF;
  localparam int unsigned BANK_MASK    = 32'h3C000;
  localparam int unsigned LOW_MASK     = 32'h3FFF;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_WORDS  = 156;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LIMIT_CYCLES = 500000;

  typedef struct {
    cmd_t             op;
    logic [IDX_W-1:0] index;
    logic [7:0]       value;
    logic [3:0]       nib;
    logic [3:0]       count;
  } rom_cmd_t;

  typedef struct {
    logic [7:0]        bits;
    logic [ADDR_W-1:0] addr;
  } read_result_t;

  class rom_reader_scoreboard;
    byte unsigned store[ROM_BYTES];
    bit           filled[ROM_BYTES];
    int unsigned  rom_addr;
    int unsigned  nib_shift;
    int unsigned  bits_left;
    int unsigned  rom_length;
    read_result_t awaiting[$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  op_count[4];

    function new();
      rom_addr   = 0;
      nib_shift  = 0;
      bits_left  = 0;
      rom_length = ROM_LENGTH_RESET;
    endfunction

    function int unsigned limit();
      return (rom_length > ROM_BYTES) ? ROM_BYTES : rom_length;
    endfunction

    // Applies one accepted command word and queues the result it must yield.
    function void note_input(rom_cmd_t w);
      int unsigned  lim;
      int unsigned  cnt;
      int unsigned  val;
      int unsigned  mask;
      int unsigned  bank;
      read_result_t r;
      lim = limit();
      val = 0;
      op_count[w.op]++;
      case (w.op)
        CMD_WRITE: begin
          store[w.index]  = w.value;
          filled[w.index] = 1'b1;
        end
        CMD_NIBBLE: begin
          if (nib_shift < SHIFT_SAT) begin
            rom_addr = ((rom_addr & ~(32'hF << nib_shift)) | (32'(w.nib) << nib_shift))
                       & ADDR_MASK;
            nib_shift += 4;
          end
          bits_left = BYTE_BITS;
        end
        CMD_READ: begin
          cnt = (w.count > 8) ? 8 : w.count;
          // The first read after an address load gives up one bit.
          if (nib_shift != 0) begin
            nib_shift = 0;
            if (cnt > 0) cnt--;
          end
          if (rom_addr < lim) begin
            mask = 32'hFF >> (8 - cnt);
            if (cnt < bits_left) begin
              bits_left -= cnt;
              val = (32'(store[rom_addr]) >> bits_left) & mask;
            end else begin
              val = 32'(store[rom_addr]) << 8;
              rom_addr = (rom_addr + 1) & ADDR_MASK;
              if (rom_addr < lim) val |= store[rom_addr];
              bits_left = (bits_left + 8 - cnt) & 32'hF;
              val = (val >> bits_left) & mask;
            end
          end
        end
        CMD_BRANCH: begin
          bank = rom_addr & BANK_MASK;
          if (rom_addr + 1 < lim)
            rom_addr = bank | (((32'(store[rom_addr]) << 8) | store[rom_addr + 1]) & LOW_MASK);
          else if (rom_addr < lim)
            rom_addr = bank | ((32'(store[rom_addr]) << 8) & LOW_MASK);
          else
            rom_addr = bank;
          bits_left = BYTE_BITS;
        end
      endcase
      r.bits = val[7:0];
      r.addr = rom_addr[ADDR_W-1:0];
      awaiting.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s at result %0d: expected 0x%0h, got 0x%0h",
                 what, results_checked, want, got);
    endfunction

    function void check_result(logic [7:0] bits, logic [ADDR_W-1:0] addr);
      read_result_t want;
      results_checked++;
      if (awaiting.size() == 0) begin
        flag("result word with no command pending", 0, {bits, addr});
        return;
      end
      want = awaiting.pop_front();
      if (bits !== want.bits) flag("bits_out", want.bits, bits);
      if (addr !== want.addr) flag("address_now", want.addr, addr);
    endfunction
  endclass

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [1:0]           cmd         = '0;
  logic [IDX_W-1:0]     rom_index   = '0;
  logic [7:0]           rom_byte    = '0;
  logic [3:0]           nibble      = '0;
  logic [3:0]           bit_count   = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [7:0]           bits_out;
  logic [ADDR_W-1:0]    address_now;

  rom_reader_scoreboard sb;
  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct     = 0;
  int unsigned          words_sent    = 0;
  int unsigned          cycle_count   = 0;

  speech_rom_serial_reader_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .rom_index   (rom_index),
    .rom_byte    (rom_byte),
    .nibble      (nibble),
    .bit_count   (bit_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bits_out    (bits_out),
    .address_now (address_now)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result(bits_out, address_now);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d result words outstanding.",
               cycle_count, sb.awaiting.size());
      $display("speech_rom_serial_reader_core verification failed");
      $finish;
    end
  end

  function automatic rom_cmd_t word_of(cmd_t op, logic [IDX_W-1:0] index, logic [7:0] value,
                                       logic [3:0] nib, logic [3:0] count);
    rom_cmd_t w;
    w.op    = op;
    w.index = index;
    w.value = value;
    w.nib   = nib;
    w.count = count;
    return w;
  endfunction

  function automatic logic [3:0] random_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 4'd0;
    if (r < 14) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  // Presents one word and holds it until the core takes it.
  task automatic drive_word(rom_cmd_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= w.op;
    rom_index <= w.index;
    rom_byte  <= w.value;
    nibble    <= w.nib;
    bit_count <= w.count;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(w);
    words_sent++;
  endtask

  // The store port may fetch both bytes of a read even when the result
  // ignores one, so both are written first if they never were.
  task automatic send_word(rom_cmd_t w);
    logic [IDX_W-1:0] idx[2];
    if (w.op == CMD_READ || w.op == CMD_BRANCH) begin
      idx[0] = sb.rom_addr[IDX_W-1:0];
      idx[1] = IDX_W'(sb.rom_addr + 1);
      foreach (idx[i])
        if (!sb.filled[idx[i]])
          drive_word(word_of(CMD_WRITE, idx[i], 8'($urandom_range(255)), 4'd0, 4'd0));
    end
    drive_word(w);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_sequence();
    int unsigned kind;
    int unsigned lim;
    int unsigned target;
    int unsigned n_nib;
    int unsigned start;
    logic [3:0]  nib;
    kind = $urandom_range(99);
    lim  = sb.limit();
    if (kind < 70) begin
      // Address load followed by a run of reads and branches.
      case ($urandom_range(3))
        0:       target = $urandom_range(0, lim - 1);
        1:       target = (lim >= 2) ? $urandom_range(lim - 2, lim - 1) : 0;
        2:       target = $urandom_range(lim, ADDR_MASK);
        default: target = $urandom_range(0, ADDR_MASK);
      endcase
      if (sb.nib_shift != 0)
        send_word(word_of(CMD_READ, '0, '0, '0, random_count()));
      case ($urandom_range(9))
        0:       n_nib = $urandom_range(1, 4);
        1, 2:    n_nib = $urandom_range(6, 8);
        default: n_nib = 5;
      endcase
      for (int k = 0; k < n_nib; k++) begin
        if (k < 4)
          nib = 4'(target >> (4 * k));
        else if (k == 4)
          nib = {2'($urandom_range(3)), 2'(target >> 16)};
        else
          nib = 4'($urandom_range(15));
        send_word(word_of(CMD_NIBBLE, IDX_W'($urandom), 8'($urandom), nib, 4'($urandom)));
      end
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(99) < 20)
          send_word(word_of(CMD_BRANCH, IDX_W'($urandom), 8'($urandom), 4'($urandom),
                            4'($urandom)));
        else
          send_word(word_of(CMD_READ, IDX_W'($urandom), 8'($urandom), 4'($urandom),
                            random_count()));
      end
    end else if (kind < 85) begin
      send_word(word_of(cmd_t'($urandom_range(3)), IDX_W'($urandom), 8'($urandom),
                        4'($urandom), 4'($urandom)));
    end else if (kind < 95) begin
      start = $urandom_range(0, ROM_BYTES - 1);
      for (int i = 0; i < $urandom_range(2, 10); i++)
        send_word(word_of(CMD_WRITE, IDX_W'(start + i), 8'($urandom), 4'($urandom),
                          4'($urandom)));
    end else begin
      drain_pipeline();
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned phase_start;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: field extremes, first-read loss, zero and oversized
    // counts, a branch with both bytes valid and one with only the last byte.
    send_word(word_of(CMD_WRITE, 15'd0, 8'hA5, '0, '0));
    send_word(word_of(CMD_WRITE, 15'd1, 8'h3C, '0, '0));
    send_word(word_of(CMD_WRITE, 15'd2, 8'hFF, '0, '0));
    send_word(word_of(CMD_WRITE, 15'd3, 8'h00, '0, '0));
    send_word(word_of(CMD_WRITE, 15'h7FFF, 8'h81, '0, '0));
    repeat (5) send_word(word_of(CMD_NIBBLE, '0, '0, 4'h0, '0));
    send_word(word_of(CMD_NIBBLE, '0, '0, 4'hF, '0));
    send_word(word_of(CMD_READ, '0, '0, '0, 4'd8));
    send_word(word_of(CMD_READ, '0, '0, '0, 4'd0));
    send_word(word_of(CMD_READ, '0, '0, '0, 4'd15));
    send_word(word_of(CMD_READ, '0, '0, '0, 4'd1));
    send_word(word_of(CMD_BRANCH, '0, '0, '0, '0));
    send_word(word_of(CMD_NIBBLE, '0, '0, 4'hF, '0));
    send_word(word_of(CMD_NIBBLE, '0, '0, 4'hF, '0));
    send_word(word_of(CMD_NIBBLE, '0, '0, 4'hF, '0));
    send_word(word_of(CMD_NIBBLE, '0, '0, 4'h7, '0));
    send_word(word_of(CMD_NIBBLE, '0, '0, 4'hC, '0));
    send_word(word_of(CMD_BRANCH, '0, '0, '0, '0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipeline();
      if (ph > 0) begin
        case (ph)
          1:       len = 1;
          2:       len = ROM_BYTES;
          3:       len = $urandom_range(2, 300);
          4:       len = 2;
          5:       len = $urandom_range(1, ROM_BYTES);
          6:       len = ROM_BYTES - 1;
          default: len = $urandom_range(16, 64);
        endcase
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LEN_W'(len);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.rom_length = len;
      end
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 46; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) run_sequence();
    end

    drain_pipeline();
    $display("Sent %0d command words: %0d writes, %0d nibbles, %0d reads, %0d branches.",
             words_sent, sb.op_count[CMD_WRITE], sb.op_count[CMD_NIBBLE],
             sb.op_count[CMD_READ], sb.op_count[CMD_BRANCH]);
    $display("Checked %0d result words over %0d ROM length phases, %0d mismatches.",
             sb.results_checked, NUM_PHASES, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaiting.size() == 0) begin
      $display("speech_rom_serial_reader_core verification clean");
    end else begin
      $display("speech_rom_serial_reader_core verification failed");
    end
    $finish;
  end

endmodule
